@@ src/tbcl_pkg.sv @@
package tbcl_pkg;

	// Width of the stored timestamps; differences wrap modulo 2^TIME_WIDTH.
	localparam int TIME_WIDTH = 32;
	localparam int NOW_WIDTH  = 32;
	localparam int CFG_WIDTH  = 16;
	localparam int IDX_WIDTH  = 2;
	localparam int NUM_BTN    = 3;

	// Configuration register indexes.
	localparam logic [IDX_WIDTH-1:0] REG_SAMPLE_INTERVAL = 2'd0;
	localparam logic [IDX_WIDTH-1:0] REG_CLICK_WINDOW    = 2'd1;
	localparam logic [IDX_WIDTH-1:0] REG_HOLD_TIME       = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [CFG_WIDTH-1:0] RST_SAMPLE_INTERVAL = 16'd100;
	localparam logic [CFG_WIDTH-1:0] RST_CLICK_WINDOW    = 16'd1000;
	localparam logic [CFG_WIDTH-1:0] RST_HOLD_TIME       = 16'd1000;

	// Per-button class.
	localparam logic [1:0] CLS_IDLE    = 2'd0;
	localparam logic [1:0] CLS_CLICK   = 2'd1;
	localparam logic [1:0] CLS_PRESSED = 2'd2;
	localparam logic [1:0] CLS_LONG    = 2'd3;

	// Combined action codes.
	localparam logic [3:0] CODE_NONE        = 4'd0;
	localparam logic [3:0] CODE_ALL_PRESSED = 4'd10;
	localparam logic [3:0] CODE_ALL_LONG    = 4'd11;

	// Each button's codes start at base + class (start-stop, next, previous).
	localparam logic [3:0] BTN_BASE [NUM_BTN] = '{4'd0, 4'd3, 4'd6};

	typedef struct packed {
		logic [CFG_WIDTH-1:0] sample_interval;
		logic [CFG_WIDTH-1:0] click_window;
		logic [CFG_WIDTH-1:0] hold_time;
	} cfg_t;

	// Per-request control shared by all button units.
	typedef struct packed {
		logic                  fire;
		logic                  mark;
		logic                  once;
		logic [TIME_WIDTH-1:0] now;
	} btn_ctl_t;

endpackage

@@ src/tbcl_cfg.sv @@
module tbcl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [tbcl_pkg::IDX_WIDTH-1:0] wr_index,
	input  logic [tbcl_pkg::CFG_WIDTH-1:0] wr_data,
	output tbcl_pkg::cfg_t                cfg
);
	import tbcl_pkg::*;

	cfg_t cfg_q;

	// Register file; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_interval <= RST_SAMPLE_INTERVAL;
			cfg_q.click_window    <= RST_CLICK_WINDOW;
			cfg_q.hold_time       <= RST_HOLD_TIME;
		end else if (wr_en) begin
			case (wr_index)
				REG_SAMPLE_INTERVAL: cfg_q.sample_interval <= wr_data;
				REG_CLICK_WINDOW:    cfg_q.click_window    <= wr_data;
				REG_HOLD_TIME:       cfg_q.hold_time       <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/tbcl_btn.sv @@
module tbcl_btn (
	input  logic               clk,
	input  logic               arst_n,
	input  tbcl_pkg::btn_ctl_t ctl,
	input  tbcl_pkg::cfg_t     cfg,
	input  logic               level,
	output logic [1:0]         cls
);
	import tbcl_pkg::*;

	logic [TIME_WIDTH-1:0] chk_q, press_q, rel_q;
	logic                  down_q, handled_q, clicked_q;

	logic [TIME_WIDTH-1:0] since_chk, since_press, since_rel;
	logic [TIME_WIDTH-1:0] press_n, rel_n;
	logic                  do_sample, down_n, in_window, is_long;
	logic                  handled_n, clicked_n;

	// Resample decision and the updated sample state.
	always_comb begin
		since_chk = ctl.now - chk_q;
		do_sample = since_chk > TIME_WIDTH'(cfg.sample_interval);
		down_n    = do_sample ? level : down_q;
		press_n   = (do_sample && level) ? ctl.now : press_q;
		rel_n     = (do_sample && !level) ? ctl.now : rel_q;
	end

	// Window and hold checks against the freshly updated times.
	always_comb begin
		since_press = ctl.now - press_n;
		since_rel   = ctl.now - rel_n;
		in_window   = since_press < TIME_WIDTH'(cfg.click_window);
		is_long     = since_rel > TIME_WIDTH'(cfg.hold_time);
	end

	// Classification; a handled button stays silent until released and out of window.
	always_comb begin
		handled_n = handled_q;
		clicked_n = clicked_q;
		cls       = CLS_IDLE;
		if (ctl.mark) begin
			handled_n = 1'b1;
		end else if (handled_q) begin
			handled_n = down_n || in_window;
		end else if (down_n) begin
			clicked_n = 1'b0;
			cls       = is_long ? CLS_LONG : CLS_PRESSED;
		end else if (in_window && (!ctl.once || !clicked_q)) begin
			if (ctl.once) begin
				clicked_n = 1'b1;
			end
			cls = CLS_CLICK;
		end
	end

	// State update, once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_q     <= '0;
			press_q   <= '0;
			rel_q     <= '0;
			down_q    <= 1'b0;
			handled_q <= 1'b0;
			clicked_q <= 1'b0;
		end else if (ctl.fire) begin
			handled_q <= handled_n;
			clicked_q <= clicked_n;
			if (!ctl.mark && do_sample) begin
				chk_q  <= ctl.now;
				down_q <= down_n;
				press_q <= press_n;
				rel_q  <= rel_n;
			end
		end
	end

	// A mark request always leaves the button handled.
	a_mark_sets: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && ctl.mark |=> handled_q)
		else $error("mark request did not set handled flag");

	// A button that reports anything was not handled.
	a_handled_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && (cls != CLS_IDLE) |-> !handled_q && !ctl.mark)
		else $error("handled button reported a class");

	// A pressed or long class clears the click-reported bit.
	a_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && cls[1] |=> !clicked_q)
		else $error("pressed button kept its click-reported bit");

endmodule

@@ src/three_button_click_long_press_classifier_top.sv @@
// Channel  Handshake             Payload
// in       in_valid / in_stall   action, now_ms, start_stop_down, next_down,
//                                previous_down, report_once
// out      out_valid / out_stall action_code
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken every cycle while the output side keeps up; the
// per-button state update is a loop closed through its state registers, which sets that rate.
// A request lands in the input register at the edge that takes it; the
// result register then loads its code, which is offered on action_code.
// Reset (arst_n low) clears all button state and loads the configuration
// defaults. A stalled result holds the input register, and in_stall rises
// only while that register is occupied. cfg_ready is always high.
module three_button_click_long_press_classifier_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [tbcl_pkg::NOW_WIDTH-1:0] now_ms,
	input  logic                           start_stop_down,
	input  logic                           next_down,
	input  logic                           previous_down,
	input  logic                           report_once,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [3:0]                     action_code,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tbcl_pkg::IDX_WIDTH-1:0] cfg_index,
	input  logic [tbcl_pkg::CFG_WIDTH-1:0] cfg_data
);
	import tbcl_pkg::*;

	cfg_t                 cfg;
	btn_ctl_t             ctl;
	logic                 valid_s1, advance;
	logic                 action_s1, once_s1;
	logic [NOW_WIDTH-1:0] now_s1;
	logic [NUM_BTN-1:0]   level_s1;
	logic [1:0]           cls [NUM_BTN];
	logic [3:0]           code_n, code_q;
	logic                 out_valid_q;

	assign cfg_ready = 1'b1;

	tbcl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Flow control: the input register moves on whenever the result register frees up.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			now_s1    <= now_ms;
			once_s1   <= report_once;
			level_s1  <= {previous_down, next_down, start_stop_down};
		end
	end

	// Control for the button units.
	always_comb begin
		ctl.fire = valid_s1 && advance;
		ctl.mark = action_s1;
		ctl.once = once_s1;
		ctl.now  = TIME_WIDTH'(now_s1);
	end

	for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
		tbcl_btn u_btn (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.cfg    (cfg),
			.level  (level_s1[b]),
			.cls    (cls[b])
		);
	end

	// Combined code: all three held first, then start-stop, next, previous.
	always_comb begin
		code_n = CODE_NONE;
		if (cls[0][1] && cls[1][1] && cls[2][1]) begin
			code_n = (cls[0] == CLS_LONG && cls[1] == CLS_LONG && cls[2] == CLS_LONG)
				? CODE_ALL_LONG : CODE_ALL_PRESSED;
		end else if (cls[0] != CLS_IDLE) begin
			code_n = BTN_BASE[0] + 4'(cls[0]);
		end else if (cls[1] != CLS_IDLE) begin
			code_n = BTN_BASE[1] + 4'(cls[1]);
		end else if (cls[2] != CLS_IDLE) begin
			code_n = BTN_BASE[2] + 4'(cls[2]);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			code_q <= code_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign action_code = code_q;

	// The input side stalls only with an occupied input register.
	a_stall_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A mark request yields no action.
	a_mark_none: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && action_s1 |=> out_valid && action_code == CODE_NONE)
		else $error("mark request produced an action code");

	// Codes stay within the defined range.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire |-> code_n <= CODE_ALL_LONG)
		else $error("action code out of range");

endmodule

@@ sim/tb_three_button_click_long_press_classifier_top.sv @@
module tb_three_button_click_long_press_classifier_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tbcl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	// One poll or mark-handled request as presented on the input channel.
	typedef struct {
		logic                 action;
		logic [NOW_WIDTH-1:0] now;
		logic                 start_stop_down;
		logic                 next_down;
		logic                 previous_down;
		logic                 report_once;
	} button_req_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 action = 1'b0;
	logic [NOW_WIDTH-1:0] now_ms = '0;
	logic                 start_stop_down = 1'b0;
	logic                 next_down = 1'b0;
	logic                 previous_down = 1'b0;
	logic                 report_once = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [3:0]           action_code;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_WIDTH-1:0] cfg_data = '0;

	three_button_click_long_press_classifier_top DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.action          (action),
		.now_ms          (now_ms),
		.start_stop_down (start_stop_down),
		.next_down       (next_down),
		.previous_down   (previous_down),
		.report_once     (report_once),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.action_code     (action_code),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	// Requests waiting to be sent, the one on the bus, and the codes still owed.
	button_req_t pending_polls [$];
	button_req_t cur_req;
	logic [3:0]  expected_codes [$];
	bit          req_taken = 1'b0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          errors = 0;
	int          cycles = 0;

	// Shadow of the configuration registers.
	logic [CFG_WIDTH-1:0] sh_sample = RST_SAMPLE_INTERVAL;
	logic [CFG_WIDTH-1:0] sh_window = RST_CLICK_WINDOW;
	logic [CFG_WIDTH-1:0] sh_long   = RST_HOLD_TIME;

	// Shadow of the per-button state.
	logic [TIME_WIDTH-1:0] chk_time [NUM_BTN] = '{default: '0};
	logic [TIME_WIDTH-1:0] prs_time [NUM_BTN] = '{default: '0};
	logic [TIME_WIDTH-1:0] rel_time [NUM_BTN] = '{default: '0};
	logic                  held     [NUM_BTN] = '{default: 1'b0};
	logic                  handled  [NUM_BTN] = '{default: 1'b0};
	logic                  clicked  [NUM_BTN] = '{default: 1'b0};

	// Stimulus generator state: running clock and current button levels.
	logic [NOW_WIDTH-1:0] run_time = '0;
	logic [NUM_BTN-1:0]   levels = '0;

	// Applies one request to the shadow state and returns the code it should give.
	function automatic logic [3:0] predict_action_code(button_req_t r);
		logic [1:0]            cls [NUM_BTN];
		logic [NUM_BTN-1:0]    lvl;
		logic [TIME_WIDTH-1:0] dt;
		logic                  in_win;
		logic [3:0]            code;
		if (r.action) begin
			for (int b = 0; b < NUM_BTN; b++)
				handled[b] = 1'b1;
			return CODE_NONE;
		end
		lvl = {r.previous_down, r.next_down, r.start_stop_down};
		for (int b = 0; b < NUM_BTN; b++) begin
			// Resample once the sample interval has been exceeded.
			dt = r.now - chk_time[b];
			if (dt > TIME_WIDTH'(sh_sample)) begin
				chk_time[b] = r.now;
				held[b] = lvl[b];
				if (lvl[b])
					prs_time[b] = r.now;
				else
					rel_time[b] = r.now;
			end
			dt = r.now - prs_time[b];
			in_win = (dt < TIME_WIDTH'(sh_window));
			cls[b] = CLS_IDLE;
			if (handled[b]) begin
				handled[b] = held[b] || in_win;
			end else if (held[b]) begin
				clicked[b] = 1'b0;
				dt = r.now - rel_time[b];
				cls[b] = (dt > TIME_WIDTH'(sh_long)) ? CLS_LONG : CLS_PRESSED;
			end else if (in_win && (!r.report_once || !clicked[b])) begin
				if (r.report_once)
					clicked[b] = 1'b1;
				cls[b] = CLS_CLICK;
			end
		end
		code = CODE_NONE;
		if (cls[0] >= CLS_PRESSED && cls[1] >= CLS_PRESSED && cls[2] >= CLS_PRESSED) begin
			code = (cls[0] == CLS_LONG && cls[1] == CLS_LONG && cls[2] == CLS_LONG) ?
				CODE_ALL_LONG : CODE_ALL_PRESSED;
		end else begin
			// Walk down so the first active button in priority order wins.
			for (int b = NUM_BTN - 1; b >= 0; b--)
				if (cls[b] != CLS_IDLE)
					code = BTN_BASE[b] + 4'(cls[b]);
		end
		return code;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// Request driver: a new request goes out only once the previous one was taken.
	always @(negedge clk) begin
		if (!in_valid || req_taken) begin
			req_taken = 1'b0;
			if (pending_polls.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				cur_req = pending_polls.pop_front();
				in_valid <= 1'b1;
				action <= cur_req.action;
				now_ms <= cur_req.now;
				start_stop_down <= cur_req.start_stop_down;
				next_down <= cur_req.next_down;
				previous_down <= cur_req.previous_down;
				report_once <= cur_req.report_once;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Monitor: check each result, then record the expectation of a newly taken request.
	always @(posedge clk) begin
		logic [3:0] want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_codes.size() == 0) begin
				report_mismatch($sformatf("code %0d with no request outstanding", action_code));
			end else begin
				want = expected_codes.pop_front();
				if (action_code !== want)
					report_mismatch($sformatf("action_code %0d, expected %0d", action_code, want));
			end
		end
		if (arst_n && in_valid && in_stall === 1'b0) begin
			expected_codes.push_back(predict_action_code(cur_req));
			req_taken = 1'b1;
		end
	end

	task automatic push_req(input logic act, input logic [NOW_WIDTH-1:0] t,
			input logic [NUM_BTN-1:0] lv, input logic once);
		button_req_t r;
		r.action = act;
		r.now = t;
		r.start_stop_down = lv[0];
		r.next_down = lv[1];
		r.previous_down = lv[2];
		r.report_once = once;
		pending_polls.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_polls.size() != 0 || in_valid || expected_codes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_SAMPLE_INTERVAL: sh_sample = val;
			REG_CLICK_WINDOW:    sh_window = val;
			REG_HOLD_TIME:       sh_long = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reconfigure only with the pipe empty.
	task automatic set_config(input int si, input int cw, input int lp);
		wait_drained();
		repeat (4) @(posedge clk);
		write_reg(REG_SAMPLE_INTERVAL, si[CFG_WIDTH-1:0]);
		write_reg(REG_CLICK_WINDOW, cw[CFG_WIDTH-1:0]);
		write_reg(REG_HOLD_TIME, lp[CFG_WIDTH-1:0]);
	endtask

	// Mostly button sequences on a running clock; some marks and random noise.
	task automatic push_random(input int n);
		int unsigned si;
		int unsigned cw;
		int unsigned lp;
		int unsigned step;
		int          k;
		si = 32'(sh_sample);
		cw = 32'(sh_window);
		lp = 32'(sh_long);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 4) begin
				push_req(1'b1, $urandom, NUM_BTN'($urandom), 1'($urandom));
			end else if (k < 8) begin
				push_req(1'b0, $urandom, NUM_BTN'($urandom), 1'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: step = $urandom_range(0, si + 1);
					3, 4, 5: step = $urandom_range(0, cw + 1);
					6, 7:    step = $urandom_range(0, lp + 1);
					8:       step = $urandom_range(0, 3 * (si + cw + lp) + 3);
					default: step = $urandom_range(0, 2);
				endcase
				run_time = run_time + step;
				if ($urandom_range(0, 9) == 0) begin
					levels = {NUM_BTN{1'($urandom_range(0, 1))}};
				end else begin
					for (int b = 0; b < NUM_BTN; b++)
						if ($urandom_range(0, 3) == 0)
							levels[b] = ~levels[b];
				end
				push_req(1'b0, run_time, levels, 1'($urandom_range(0, 1)));
			end
		end
	endtask

	// Half the requests, a full drain with the sender paused, then the rest.
	task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		push_random(n / 2);
		wait_drained();
		push_random(n - n / 2);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle start, mark handled, each button's press, long press and
		// click, report-once suppression, all three held, and a timestamp wrap.
		push_req(1'b0, 32'd0, 3'b000, 1'b0);
		push_req(1'b1, 32'hFFFF_FFFF, 3'b111, 1'b1);
		push_req(1'b0, 32'd50, 3'b001, 1'b0);
		push_req(1'b0, 32'd2000, 3'b000, 1'b0);
		push_req(1'b0, 32'd2200, 3'b001, 1'b0);
		push_req(1'b0, 32'd3300, 3'b001, 1'b0);
		push_req(1'b0, 32'd3500, 3'b000, 1'b1);
		push_req(1'b0, 32'd3550, 3'b000, 1'b1);
		push_req(1'b0, 32'd3600, 3'b000, 1'b0);
		push_req(1'b0, 32'd5000, 3'b010, 1'b0);
		push_req(1'b0, 32'd6200, 3'b010, 1'b0);
		push_req(1'b0, 32'd6300, 3'b000, 1'b1);
		push_req(1'b0, 32'd8000, 3'b100, 1'b0);
		push_req(1'b0, 32'd9200, 3'b100, 1'b0);
		push_req(1'b0, 32'd9300, 3'b000, 1'b0);
		push_req(1'b0, 32'd11000, 3'b111, 1'b0);
		push_req(1'b0, 32'd12500, 3'b111, 1'b0);
		push_req(1'b0, 32'd12600, 3'b110, 1'b1);
		push_req(1'b1, 32'd0, 3'b000, 1'b0);
		push_req(1'b0, 32'd12800, 3'b000, 1'b0);
		push_req(1'b0, 32'd15000, 3'b000, 1'b0);
		push_req(1'b0, 32'hFFFF_FF00, 3'b111, 1'b0);
		push_req(1'b0, 32'h0000_0300, 3'b111, 1'b1);
		push_req(1'b0, 32'h0000_0400, 3'b000, 1'b1);
		wait_drained();
		run_time = 32'h0000_1000;

		run_phase(300, 0, 0);
		// Zero sample interval, zero click window, smallest nonzero hold time.
		set_config(0, 0, 1);
		run_phase(250, 85, 0);
		// All registers at their maximum, with the clock running through a wrap.
		set_config(65535, 65535, 65535);
		run_time = 32'hFFF0_0000;
		run_phase(250, 0, 85);
		set_config(0, 1, 65535);
		run_phase(250, 32, 32);
		set_config($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(1, 2000));
		run_phase(300, 0, 0);
		set_config($urandom_range(0, 2000), $urandom_range(1, 2000), $urandom_range(1, 2000));
		run_time = $urandom;
		run_phase(300, 32, 32);

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/tbcl_pkg.sv
src/tbcl_cfg.sv
src/tbcl_btn.sv
src/three_button_click_long_press_classifier_top.sv
sim/tb_three_button_click_long_press_classifier_top.sv
